// File: hw/rtl/csba_pkg.sv
// ----------------------------------------------------------------------------
// csba_pkg
// Shared widths, register indexes and reciprocal constants for the clock
// set-button auto-repeat block.
// ----------------------------------------------------------------------------
package csba_pkg;

    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int COUNT_W = 32;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [COUNT_W-1:0] count_t;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PRESS_TICKS   = 2'd0,
        REG_FIRST_DELAY   = 2'd1,
        REG_REPEAT_PERIOD = 2'd2
    } reg_idx_t;

    localparam cfg_t PRESS_TICKS_RST   = 16'd10;
    localparam cfg_t FIRST_DELAY_RST   = 16'd1000;
    localparam cfg_t REPEAT_PERIOD_RST = 16'd100;

    localparam logic [COUNT_W-1:0] MINUTE_SECS = 32'd60;

    // x / 15 = (x * RECIP15) >> RECIP15_SH, exact for x < 2^30
    localparam logic [30:0] RECIP15    = 31'd1145324613;
    localparam int          RECIP15_SH = 34;
    // x / 3 = (x * RECIP3) >> RECIP3_SH, exact for x < 2^18
    localparam logic [18:0] RECIP3     = 19'd349526;
    localparam int          RECIP3_SH  = 20;

endpackage

// File: hw/rtl/clock_set_button_autorepeat.sv
// ----------------------------------------------------------------------------
// clock_set_button_autorepeat
// Set-button auto-repeat: minute advance strobe with hour/minute/second split.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one tick per beat: button level and the present clock
//   count in seconds. Every input beat yields exactly one m_ beat. When the
//   hold counter reaches press_ticks the result carries m_set_strobe with the
//   count rounded up to the next whole minute and its hours (mod 24), minutes
//   and seconds; otherwise those fields are zero. m_repeat_lamp shows the
//   auto-repeat state after the tick.
//   A beat passes five registered stages, a to e, on its way to m_valid;
//   one beat is taken each cycle unless m_ready stalls the pipeline. Its
//   three reciprocal divides by 60, 60 and 24 each feed a register.
//   Hold counter, hold limit and lamp update in the cycle a beat is accepted.
//   cfg_we writes one register (press_ticks, first_delay, repeat_period)
//   per cycle; unknown indexes are dropped.
//   Synchronous reset empties the pipeline and restores register defaults.
//   When m_ready is low results wait in the pipeline; bubbles still fill, and
//   s_ready drops only once all five stages hold a beat.
// ----------------------------------------------------------------------------
module clock_set_button_autorepeat #(
    parameter int HOLD_WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic [csba_pkg::IDX_W-1:0] cfg_index,
    input  csba_pkg::cfg_t           cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_button_level,
    input  csba_pkg::count_t         s_current_count,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_set_strobe,
    output csba_pkg::count_t         m_new_count,
    output logic [csba_pkg::HOUR_W-1:0] m_hours,
    output logic [csba_pkg::MIN_W-1:0]  m_minutes,
    output logic [csba_pkg::SEC_W-1:0]  m_seconds,
    output logic                     m_repeat_lamp
);
    import csba_pkg::*;

    localparam int CMP_W = (HOLD_WIDTH > CFG_W) ? HOLD_WIDTH : CFG_W;

    // configuration and hold state
    cfg_t                  press_ticks_reg, first_delay_reg, repeat_period_reg;
    logic [HOLD_WIDTH-1:0] hold_count_reg, hold_count_next;
    cfg_t                  hold_limit_reg, hold_limit_next;
    logic                  lamp_reg, lamp_next;
    logic                  strobe_next;
    logic [HOLD_WIDTH-1:0] hold_inc;

    // pipeline valids and handshakes
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;
    logic accept;

    // stage payloads
    logic        a_strobe_reg, a_lamp_reg;
    count_t      a_sum_reg;
    logic        b_strobe_reg, b_lamp_reg;
    logic [26:0] b_q_reg;
    logic        c_strobe_reg, c_lamp_reg;
    logic [26:0] c_q_reg;
    logic [20:0] c_h_reg;
    count_t      c_count_reg;
    logic        d_strobe_reg, d_lamp_reg;
    logic [20:0] d_h_reg;
    logic [15:0] d_days_reg;
    logic [MIN_W-1:0] d_min_reg;
    count_t      d_count_reg;
    logic        e_strobe_reg, e_lamp_reg;
    logic [HOUR_W-1:0] e_hours_reg;
    logic [MIN_W-1:0]  e_min_reg;
    count_t      e_count_reg;

    logic [60:0] prod_b;
    logic [55:0] prod_c;
    logic [36:0] prod_d;
    logic [26:0] h_times60;
    logic [20:0] d_times24;

    function automatic logic [24:0] c_q_in_shift(input logic [26:0] q);
        return q[26:2];
    endfunction

    assign e_rdy   = !e_valid_reg || m_ready;
    assign d_rdy   = !d_valid_reg || e_rdy;
    assign c_rdy   = !c_valid_reg || d_rdy;
    assign b_rdy   = !b_valid_reg || c_rdy;
    assign a_rdy   = !a_valid_reg || b_rdy;
    assign s_ready = a_rdy;
    assign accept  = s_valid && a_rdy;

    // hold counter, limit and lamp for the tick being accepted
    assign hold_inc = hold_count_reg + HOLD_WIDTH'(1);

    always_comb begin
        hold_count_next = hold_count_reg;
        hold_limit_next = hold_limit_reg;
        lamp_next       = lamp_reg;
        strobe_next     = 1'b0;
        if (s_button_level) begin
            priority if (CMP_W'(hold_inc) == CMP_W'(press_ticks_reg)) begin
                hold_count_next = hold_inc;
                strobe_next     = 1'b1;
            end else if (CMP_W'(hold_inc) > CMP_W'(hold_limit_reg)) begin
                hold_count_next = '0;
                hold_limit_next = repeat_period_reg;
                lamp_next       = 1'b1;
            end else begin
                hold_count_next = hold_inc;
            end
        end else begin
            hold_count_next = '0;
            hold_limit_next = first_delay_reg;
            lamp_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_ticks_reg   <= PRESS_TICKS_RST;
            first_delay_reg   <= FIRST_DELAY_RST;
            repeat_period_reg <= REPEAT_PERIOD_RST;
            hold_count_reg    <= '0;
            hold_limit_reg    <= FIRST_DELAY_RST;
            lamp_reg          <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PRESS_TICKS:   press_ticks_reg   <= cfg_wdata;
                    REG_FIRST_DELAY:   first_delay_reg   <= cfg_wdata;
                    REG_REPEAT_PERIOD: repeat_period_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                hold_count_reg <= hold_count_next;
                hold_limit_reg <= hold_limit_next;
                lamp_reg       <= lamp_next;
            end
        end
    end

    // divide by 60 as (x >> 2) / 15, twice, then by 24 as (x >> 3) / 3
    assign prod_b    = 61'(a_sum_reg[31:2]) * 61'(RECIP15);
    assign prod_c    = 56'(c_q_in_shift(b_q_reg)) * 56'(RECIP15);
    assign prod_d    = 37'(c_h_reg[20:3]) * 37'(RECIP3);
    assign h_times60 = (27'(c_h_reg) << 6) - (27'(c_h_reg) << 2);
    assign d_times24 = (21'(d_days_reg) << 4) + (21'(d_days_reg) << 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) a_valid_reg <= s_valid;
            if (b_rdy) b_valid_reg <= a_valid_reg;
            if (c_rdy) c_valid_reg <= b_valid_reg;
            if (d_rdy) d_valid_reg <= c_valid_reg;
            if (e_rdy) e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_strobe_reg <= strobe_next;
            a_lamp_reg   <= lamp_next;
            a_sum_reg    <= s_current_count + MINUTE_SECS;
        end
        if (b_rdy) begin
            b_strobe_reg <= a_strobe_reg;
            b_lamp_reg   <= a_lamp_reg;
            b_q_reg      <= prod_b[RECIP15_SH+26:RECIP15_SH];
        end
        if (c_rdy) begin
            c_strobe_reg <= b_strobe_reg;
            c_lamp_reg   <= b_lamp_reg;
            c_q_reg      <= b_q_reg;
            c_h_reg      <= prod_c[RECIP15_SH+20:RECIP15_SH];
            c_count_reg  <= (COUNT_W'(b_q_reg) << 6) - (COUNT_W'(b_q_reg) << 2);
        end
        if (d_rdy) begin
            d_strobe_reg <= c_strobe_reg;
            d_lamp_reg   <= c_lamp_reg;
            d_h_reg      <= c_h_reg;
            d_days_reg   <= prod_d[RECIP3_SH+15:RECIP3_SH];
            d_min_reg    <= MIN_W'(c_q_reg - h_times60);
            d_count_reg  <= c_count_reg;
        end
        if (e_rdy) begin
            e_strobe_reg <= d_strobe_reg;
            e_lamp_reg   <= d_lamp_reg;
            // no strobe: time fields read as zero
            e_hours_reg  <= d_strobe_reg ? HOUR_W'(d_h_reg - d_times24) : '0;
            e_min_reg    <= d_strobe_reg ? d_min_reg : '0;
            e_count_reg  <= d_strobe_reg ? d_count_reg : '0;
        end
    end

    assign m_valid       = e_valid_reg;
    assign m_set_strobe  = e_strobe_reg;
    assign m_new_count   = e_count_reg;
    assign m_hours       = e_hours_reg;
    assign m_minutes     = e_min_reg;
    assign m_seconds     = '0;
    assign m_repeat_lamp = e_lamp_reg;

endmodule

// File: hw/rtl/csba_checker.sv
// ----------------------------------------------------------------------------
// csba_checker
// Port-level checks on the result channel of the set-button block.
// ----------------------------------------------------------------------------
module csba_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_set_strobe,
    input csba_pkg::count_t            m_new_count,
    input logic [csba_pkg::HOUR_W-1:0] m_hours,
    input logic [csba_pkg::MIN_W-1:0]  m_minutes,
    input logic [csba_pkg::SEC_W-1:0]  m_seconds
);
    import csba_pkg::*;

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a beat without strobe carries no time
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_set_strobe) |->
        (m_new_count == '0 && m_hours == '0 && m_minutes == '0 && m_seconds == '0))
        else $error("time fields set without strobe");

    // a strobe beat holds a split time of day on a whole minute
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_set_strobe) |->
        (m_seconds == '0 && m_minutes < MIN_W'(60) && m_hours < HOUR_W'(24)))
        else $error("time split out of range");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_new_count) && $stable(m_set_strobe)))
        else $error("result beat changed while stalled");

endmodule

bind clock_set_button_autorepeat csba_checker u_csba_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_set_strobe (m_set_strobe),
    .m_new_count  (m_new_count),
    .m_hours      (m_hours),
    .m_minutes    (m_minutes),
    .m_seconds    (m_seconds)
);

// File: tb/clock_set_button_autorepeat_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_set_button_autorepeat_tb
// Self-checking bench for the set-button auto-repeat block. Ticks go in on
// the s_ channel and every m_ beat is compared field by field with a
// tick-accurate model of the hold counter, the repeat lamp and the
// minute rounding with its hour/minute/second split.
// ----------------------------------------------------------------------------
module clock_set_button_autorepeat_tb;
    import csba_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 12;
    localparam int     HOLD_W        = 16;
    localparam int     PIPE_LATENCY  = 5;
    localparam int     CYCLE_LIMIT   = 2000000;
    localparam int     MAX_REPORTS   = 100;
    localparam int     TICKS_PER_SET = 80;
    localparam int     SETS_PER_PASS = 3;
    localparam cfg_t   REG_MAX       = 16'hFFFF;
    localparam count_t SECS_PER_HOUR = 32'd3600;
    localparam count_t HOURS_PER_DAY = 32'd24;
    // index outside the register map, must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic               strobe;
        count_t             new_count;
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic               lamp;
    } tick_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    cfg_t               cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_button_level = 1'b0;
    count_t             s_current_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_set_strobe;
    count_t             m_new_count;
    logic [HOUR_W-1:0]  m_hours;
    logic [MIN_W-1:0]   m_minutes;
    logic [SEC_W-1:0]   m_seconds;
    logic               m_repeat_lamp;

    // model state
    cfg_t               press_ticks_q;
    cfg_t               first_delay_q;
    cfg_t               repeat_period_q;
    cfg_t               hold_limit_q;
    logic [HOLD_W-1:0]  hold_count_q;
    logic               lamp_q;

    tick_result_t       expected_results[$];
    tick_result_t       got_result;
    tick_result_t       want_result;
    int                 results_seen = 0;
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    clock_set_button_autorepeat #(
        .HOLD_WIDTH(HOLD_W)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button_level  (s_button_level),
        .s_current_count (s_current_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_set_strobe    (m_set_strobe),
        .m_new_count     (m_new_count),
        .m_hours         (m_hours),
        .m_minutes       (m_minutes),
        .m_seconds       (m_seconds),
        .m_repeat_lamp   (m_repeat_lamp)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void reset_model();
        press_ticks_q   = PRESS_TICKS_RST;
        first_delay_q   = FIRST_DELAY_RST;
        repeat_period_q = REPEAT_PERIOD_RST;
        hold_limit_q    = FIRST_DELAY_RST;
        hold_count_q    = '0;
        lamp_q          = 1'b0;
    endfunction

    function automatic void apply_reg_write(input logic [IDX_W-1:0] idx, input cfg_t val);
        case (idx)
            REG_PRESS_TICKS:   press_ticks_q = val;
            REG_FIRST_DELAY:   first_delay_q = val;
            REG_REPEAT_PERIOD: repeat_period_q = val;
            default: ;
        endcase
    endfunction

    // one tick through the hold counter; strobe carries the count rounded up
    function automatic tick_result_t hold_and_round(input logic btn, input count_t cnt);
        tick_result_t r;
        count_t       rounded;
        count_t       part;
        r = '0;
        if (btn) begin
            hold_count_q = hold_count_q + 1'b1;
            if (hold_count_q == press_ticks_q) begin
                rounded     = cnt + MINUTE_SECS;
                rounded     = (rounded / MINUTE_SECS) * MINUTE_SECS;
                r.strobe    = 1'b1;
                r.new_count = rounded;
                part        = rounded % MINUTE_SECS;
                r.seconds   = part[SEC_W-1:0];
                part        = (rounded / MINUTE_SECS) % MINUTE_SECS;
                r.minutes   = part[MIN_W-1:0];
                part        = (rounded / SECS_PER_HOUR) % HOURS_PER_DAY;
                r.hours     = part[HOUR_W-1:0];
            end else if (hold_count_q > hold_limit_q) begin
                // limit test is skipped on a strobe tick
                hold_count_q = '0;
                hold_limit_q = repeat_period_q;
                lamp_q       = 1'b1;
            end
        end else begin
            hold_count_q = '0;
            hold_limit_q = first_delay_q;
            lamp_q       = 1'b0;
        end
        r.lamp = lamp_q;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string field, input count_t got, input count_t want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, field, got, want));
        end
    endtask

    // samples both channels and the register port at every edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_we) begin
                apply_reg_write(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(hold_and_round(s_button_level, s_current_count));
            end
            if (m_valid && m_ready) begin
                got_result.strobe    = m_set_strobe;
                got_result.new_count = m_new_count;
                got_result.hours     = m_hours;
                got_result.minutes   = m_minutes;
                got_result.seconds   = m_seconds;
                got_result.lamp      = m_repeat_lamp;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("set_strobe", got_result.strobe, want_result.strobe);
                    check_field("new_count", got_result.new_count, want_result.new_count);
                    check_field("hours", got_result.hours, want_result.hours);
                    check_field("minutes", got_result.minutes, want_result.minutes);
                    check_field("seconds", got_result.seconds, want_result.seconds);
                    check_field("repeat_lamp", got_result.lamp, want_result.lamp);
                end
                results_seen++;
            end
        end
    end

    task automatic send_tick(input logic btn, input count_t cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_button_level  <= btn;
        s_current_count <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY) @(posedge aclk);
    endtask

    // spare index gets a random value each time, it must not land anywhere
    task automatic program_regs(input cfg_t press, input cfg_t first, input cfg_t rep);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PRESS_TICKS;
        cfg_wdata <= press;
        @(posedge aclk);
        cfg_index <= REG_FIRST_DELAY;
        cfg_wdata <= first;
        @(posedge aclk);
        cfg_index <= REG_REPEAT_PERIOD;
        cfg_wdata <= rep;
        @(posedge aclk);
        cfg_index <= REG_SPARE;
        cfg_wdata <= cfg_t'($urandom_range(REG_MAX));
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic count_t rand_count();
        case ($urandom_range(9))
            0:       return 32'hFFFF_FFFF - $urandom_range(119);
            1:       return $urandom_range(3599);
            2:       return ($urandom / 60) * 60 + $urandom_range(1);
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_t rand_reg(input int hi);
        if ($urandom_range(7) == 0) begin
            return cfg_t'($urandom_range(REG_MAX));
        end
        return cfg_t'($urandom_range(hi));
    endfunction

    // mostly press-hold-release runs, with some ragged button noise
    task automatic run_random_ticks(input int n);
        int sent;
        int run_len;
        int k;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                run_len = $urandom_range(40, 1);
                for (k = 0; k < run_len; k++) send_tick(1'b1, rand_count());
                sent += run_len;
                run_len = $urandom_range(3, 1);
                for (k = 0; k < run_len; k++) send_tick(1'b0, rand_count());
                sent += run_len;
            end else begin
                run_len = $urandom_range(8, 1);
                for (k = 0; k < run_len; k++) send_tick(1'($urandom_range(1)), rand_count());
                sent += run_len;
            end
        end
    endtask

    // power-on registers: tenth held tick strobes, across a day boundary
    task automatic test_reset_defaults();
        int k;
        for (k = 1; k < 10; k++) send_tick(1'b1, count_t'(k * 1000));
        send_tick(1'b1, 32'd86399);
        wait_drained();
    endtask

    // strobe on every press, counts at the rounding and wrap edges
    task automatic test_count_extremes();
        count_t edge_counts[6];
        int     k;
        edge_counts = '{32'd0, 32'd59, 32'd86399, 32'hFFFF_FFC3,
                        32'hFFFF_FFC4, 32'hFFFF_FFFF};
        program_regs(16'd1, REG_MAX, REG_MAX);
        for (k = 0; k < 6; k++) begin
            send_tick(1'b0, edge_counts[k]);
            send_tick(1'b1, edge_counts[k]);
        end
        wait_drained();
    endtask

    // first delay runs out, lamp lights, then short repeat period
    task automatic test_autorepeat();
        program_regs(16'd2, 16'd3, 16'd1);
        send_tick(1'b0, rand_count());
        repeat (9) send_tick(1'b1, rand_count());
        send_tick(1'b0, rand_count());
        wait_drained();
    endtask

    task automatic test_random_pass(input int snd_pct, input int rcv_pct,
                                    input cfg_t press, input cfg_t first, input cfg_t rep);
        int k;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        program_regs(press, first, rep);
        run_random_ticks(TICKS_PER_SET);
        for (k = 1; k < SETS_PER_PASS; k++) begin
            wait_drained();
            program_regs(rand_reg(12), rand_reg(20), rand_reg(10));
            run_random_ticks(TICKS_PER_SET);
        end
        wait_drained();
    endtask

    // zero registers: a zero limit is passed by every held tick, and
    // press_ticks 0 never matches a counter that has not wrapped
    task automatic test_zero_regs();
        program_regs(16'd0, 16'd0, 16'd0);
        send_tick(1'b0, rand_count());
        repeat (12) send_tick(1'b1, rand_count());
        send_tick(1'b0, rand_count());
        wait_drained();
        program_regs(16'd0, REG_MAX, REG_MAX);
        repeat (40) send_tick(1'b1, rand_count());
        send_tick(1'b0, rand_count());
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct  = 35;
        recv_stall_pct = 82;
        test_reset_defaults();
        test_count_extremes();
        test_autorepeat();
        test_random_pass(35, 82, 16'd3, 16'd0, 16'd5);
        test_random_pass(82, 35, 16'd2, 16'd7, 16'd0);
        test_random_pass(0, 0, 16'd4, 16'd10, 16'd3);
        test_zero_regs();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
